// ===== sv/kmga_pkg.sv =====
// shared types and constants of the k-way move gain accumulator
package kmga_pkg;

    // parts in the partition and parts carried on the item
    localparam int NUM_PARTS     = 4;
    localparam int CARRIED_PARTS = 4;
    localparam int USED_PARTS    = (NUM_PARTS < CARRIED_PARTS) ? NUM_PARTS : CARRIED_PARTS;

    // field widths
    localparam int PART_W   = 2;
    localparam int WEIGHT_W = 16;
    localparam int DEG_W    = 10;
    localparam int GAIN_W   = 20;

    localparam logic [GAIN_W-1:0] GAIN_MAX = {GAIN_W{1'b1}};

    typedef logic [DEG_W-1:0]         t_deg;
    typedef logic [GAIN_W-1:0]        t_gain;
    typedef logic [CARRIED_PARTS-1:0] t_part_sel;

    // one net of the cell
    typedef struct packed {
        logic [PART_W-1:0]   src_part;
        logic [WEIGHT_W-1:0] net_wt;
        t_deg                net_cells;
        t_deg                deg_part0;
        t_deg                deg_part1;
        t_deg                deg_part2;
        t_deg                deg_part3;
        logic                last_net;
    } t_net;

    // gains of one cell
    typedef struct packed {
        t_gain gain_part0;
        t_gain gain_part1;
        t_gain gain_part2;
        t_gain gain_part3;
    } t_gains;

    // decode result: which accumulator takes the weight
    typedef struct packed {
        t_part_sel add_sel;
    } t_net_hit;

endpackage

// ===== sv/kmga_net_if.sv =====
// valid/ready channel carrying one net request
interface kmga_net_if;
    logic          valid;
    logic          ready;
    kmga_pkg::t_net data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/kmga_gain_if.sv =====
// valid/ready channel carrying one gain request
interface kmga_gain_if;
    logic            valid;
    logic            ready;
    kmga_pkg::t_gains data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== sv/kway_move_gain_accumulator.sv =====
// k-way move gain accumulator top level
// an accepted last net passes the input register and then the output register on its way to o_gain
// throughput: one net request per cycle, set by the combinational add into the accumulators
// only a last net waits, and only while the output register is full and not taken
// reset (synchronous, active low) empties both registers and clears all gains to zero
module kway_move_gain_accumulator (
    input  logic          i_clk,
    input  logic          i_rst_n,
    kmga_net_if.sink      i_net,
    kmga_gain_if.source   o_gain
);

    kmga_pkg::t_net     r_net;
    logic               r_in_vld;
    kmga_pkg::t_gain    r_acc [kmga_pkg::CARRIED_PARTS];
    kmga_pkg::t_gain    n_acc [kmga_pkg::CARRIED_PARTS];
    kmga_pkg::t_gains   r_out;
    logic               r_out_vld;
    kmga_pkg::t_net_hit w_hit;
    logic               w_out_free;
    logic               w_advance;

    // target part of the registered net
    kmga_net_decode u_decode (
        .i_net (r_net),
        .o_hit (w_hit)
    );

    // flow control: only a last net needs room in the output register
    assign w_out_free  = !r_out_vld || o_gain.ready;
    assign w_advance   = r_in_vld && (!r_net.last_net || w_out_free);
    assign i_net.ready = !r_in_vld || w_advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else if (i_net.ready) begin
            r_in_vld <= i_net.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_net.valid && i_net.ready) begin
            r_net <= i_net.data;
        end
    end

    // saturating add of the weight into the selected accumulator
    always_comb begin
        logic [kmga_pkg::GAIN_W:0] sum;
        for (int p = 0; p < kmga_pkg::CARRIED_PARTS; p++) begin
            sum = {1'b0, r_acc[p]} + (kmga_pkg::GAIN_W + 1)'(r_net.net_wt);
            if (!w_hit.add_sel[p]) begin
                n_acc[p] = r_acc[p];
            end else if (sum[kmga_pkg::GAIN_W]) begin
                n_acc[p] = kmga_pkg::GAIN_MAX;
            end else begin
                n_acc[p] = sum[kmga_pkg::GAIN_W-1:0];
            end
        end
    end

    // accumulators, cleared once a cell's gains are handed over
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < kmga_pkg::CARRIED_PARTS; p++) begin
                r_acc[p] <= '0;
            end
        end else if (w_advance) begin
            for (int p = 0; p < kmga_pkg::CARRIED_PARTS; p++) begin
                r_acc[p] <= r_net.last_net ? '0 : n_acc[p];
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_out_free) begin
            r_out_vld <= w_advance && r_net.last_net;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && r_net.last_net) begin
            r_out.gain_part0 <= n_acc[0];
            r_out.gain_part1 <= n_acc[1];
            r_out.gain_part2 <= n_acc[2];
            r_out.gain_part3 <= n_acc[3];
        end
    end

    assign o_gain.valid = r_out_vld;
    assign o_gain.data  = r_out;

    // at most one accumulator takes a net
    a_one_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_vld |-> $onehot0(w_hit.add_sel))
        else $error("net weight routed to more than one part");

    // a net is held back only behind a full, untaken output
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_vld && !w_advance) |-> (r_net.last_net && r_out_vld && !o_gain.ready))
        else $error("net held without an output stall");

    // a finished cell leaves clear accumulators and a pending gain request
    a_cell_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && r_net.last_net) |=>
            (r_out_vld && r_acc[0] == '0 && r_acc[1] == '0 &&
             r_acc[2] == '0 && r_acc[3] == '0))
        else $error("gains not handed over or accumulators not cleared");

endmodule

// ===== sv/kmga_net_decode.sv =====
// works out which part accumulator a net's weight goes to
module kmga_net_decode (
    input  kmga_pkg::t_net     i_net,
    output kmga_pkg::t_net_hit o_hit
);

    kmga_pkg::t_deg                     w_deg [kmga_pkg::CARRIED_PARTS];
    kmga_pkg::t_deg                     w_home_deg;
    kmga_pkg::t_deg                     w_rest;
    kmga_pkg::t_part_sel                w_match;
    kmga_pkg::t_part_sel                w_first;
    kmga_pkg::t_part_sel                w_home_sel;
    logic                               w_home_used;

    // degrees as an array indexed by part
    assign w_deg[0] = i_net.deg_part0;
    assign w_deg[1] = i_net.deg_part1;
    assign w_deg[2] = i_net.deg_part2;
    assign w_deg[3] = i_net.deg_part3;

    assign w_home_deg  = w_deg[i_net.src_part];
    assign w_rest      = i_net.net_cells - kmga_pkg::DEG_W'(1);
    assign w_home_used = ({1'b0, i_net.src_part} <
                          (kmga_pkg::PART_W + 1)'(kmga_pkg::USED_PARTS));

    // parts other than home holding all remaining cells
    always_comb begin
        for (int p = 0; p < kmga_pkg::CARRIED_PARTS; p++) begin
            w_match[p] = (p < kmga_pkg::USED_PARTS) &&
                         (kmga_pkg::PART_W'(p) != i_net.src_part) &&
                         (w_deg[p] == w_rest);
            w_home_sel[p] = (kmga_pkg::PART_W'(p) == i_net.src_part);
        end
    end

    // keep the lowest matching part
    always_comb begin
        logic found;
        found   = 1'b0;
        w_first = '0;
        for (int p = 0; p < kmga_pkg::CARRIED_PARTS; p++) begin
            if (w_match[p] && !found) begin
                w_first[p] = 1'b1;
                found      = 1'b1;
            end
        end
    end

    // moving out leaves the net uncut, or staying keeps it uncut
    always_comb begin
        o_hit.add_sel = '0;
        if (w_home_used) begin
            if (w_home_deg == kmga_pkg::DEG_W'(1)) begin
                if (i_net.net_cells != '0) begin
                    o_hit.add_sel = w_first;
                end
            end else if (w_home_deg == i_net.net_cells) begin
                o_hit.add_sel = w_home_sel;
            end
        end
    end

endmodule

// ===== bench/kmga_gain_checker.sv =====
// gain predictor and scoreboard watching the net and gain channels
module kmga_gain_checker (
    input  logic  i_clk,
    input  logic  i_rst_n,
    kmga_net_if   i_net,
    kmga_gain_if  i_gain,
    output int    o_fail_count,
    output int    o_pending
);

    localparam int MAX_PRINTED = 100;

    // predicted accumulators and gains still owed by the block
    kmga_pkg::t_gain  gain_acc [kmga_pkg::CARRIED_PARTS];
    kmga_pkg::t_gains owed_gains [$];
    kmga_pkg::t_gains cell_gains;
    kmga_pkg::t_gains seen_gains;
    bit               cell_done;
    int               fail_count = 0;
    int               pending_count = 0;
    int               gains_seen = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = pending_count;

    task automatic log_mismatch(input string msg);
        if (fail_count < MAX_PRINTED) begin
            $display("%0t gain check: %s", $time, msg);
        end
        fail_count++;
    endtask

    function automatic kmga_pkg::t_gain sat_add(input kmga_pkg::t_gain acc,
                                                input logic [kmga_pkg::WEIGHT_W-1:0] weight);
        logic [kmga_pkg::GAIN_W:0] total;
        total = {1'b0, acc} + (kmga_pkg::GAIN_W + 1)'(weight);
        return (total > {1'b0, kmga_pkg::GAIN_MAX}) ? kmga_pkg::GAIN_MAX
                                                    : total[kmga_pkg::GAIN_W-1:0];
    endfunction

    // fold one net into the accumulators, hand out the gains on the last net
    task automatic accumulate_net(input kmga_pkg::t_net net, output bit done,
                                  output kmga_pkg::t_gains gains);
        kmga_pkg::t_deg deg [kmga_pkg::CARRIED_PARTS];
        int             home;
        bit             placed;
        deg[0] = net.deg_part0;
        deg[1] = net.deg_part1;
        deg[2] = net.deg_part2;
        deg[3] = net.deg_part3;
        home   = int'(net.src_part);
        placed = 1'b0;
        if (home < kmga_pkg::USED_PARTS) begin
            if (deg[home] == 1) begin
                // lone cell at home: lowest other part with all remaining cells
                if (net.net_cells >= 1) begin
                    for (int p = 0; p < kmga_pkg::USED_PARTS; p++) begin
                        if (!placed && p != home && deg[p] == net.net_cells - 1'b1) begin
                            gain_acc[p] = sat_add(gain_acc[p], net.net_wt);
                            placed = 1'b1;
                        end
                    end
                end
            end else if (deg[home] == net.net_cells) begin
                gain_acc[home] = sat_add(gain_acc[home], net.net_wt);
            end
        end
        done  = net.last_net;
        gains = '0;
        if (net.last_net) begin
            gains.gain_part0 = gain_acc[0];
            gains.gain_part1 = gain_acc[1];
            gains.gain_part2 = gain_acc[2];
            gains.gain_part3 = gain_acc[3];
            for (int p = 0; p < kmga_pkg::CARRIED_PARTS; p++) begin
                gain_acc[p] = '0;
            end
        end
    endtask

    task automatic check_field(input string name, input kmga_pkg::t_gain got,
                               input kmga_pkg::t_gain want);
        if (got !== want) begin
            log_mismatch($sformatf("cell %0d %s got %0d expected %0d",
                                   gains_seen, name, got, want));
        end
    endtask

    // sample both channels at the clock edge
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int p = 0; p < kmga_pkg::CARRIED_PARTS; p++) begin
                gain_acc[p] = '0;
            end
            owed_gains.delete();
        end else begin
            if (i_net.valid && i_net.ready) begin
                accumulate_net(i_net.data, cell_done, cell_gains);
                if (cell_done) begin
                    owed_gains.push_back(cell_gains);
                end
            end
            if (i_gain.valid && i_gain.ready) begin
                seen_gains = i_gain.data;
                if (owed_gains.size() == 0) begin
                    log_mismatch($sformatf("unexpected gain request %h", seen_gains));
                end else begin
                    cell_gains = owed_gains.pop_front();
                    check_field("gain_part0", seen_gains.gain_part0, cell_gains.gain_part0);
                    check_field("gain_part1", seen_gains.gain_part1, cell_gains.gain_part1);
                    check_field("gain_part2", seen_gains.gain_part2, cell_gains.gain_part2);
                    check_field("gain_part3", seen_gains.gain_part3, cell_gains.gain_part3);
                end
                gains_seen++;
            end
        end
        pending_count <= owed_gains.size();
    end

endmodule

// ===== bench/kway_move_gain_accumulator_tb.sv =====
// stimulus, flow control and verdict for the k-way move gain accumulator
module kway_move_gain_accumulator_tb;

    localparam int NET_TARGET   = 1350;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 8;
    localparam int SAT_NETS     = 17;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    int   fail_count;
    int   pending_gains;
    int   cycle_count = 0;
    int   nets_sent   = 0;
    int   burst_left  = 0;
    bit   hold_off_req = 1'b0;

    kmga_net_if  net_ch ();
    kmga_gain_if gain_ch ();

    kway_move_gain_accumulator u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_net   (net_ch),
        .o_gain  (gain_ch)
    );

    kmga_gain_checker u_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_net        (net_ch),
        .i_gain       (gain_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending_gains)
    );

    // clock
    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("FAIL kway_move_gain_accumulator");
            $finish;
        end
    end

    function automatic kmga_pkg::t_net mk_net(input int home, input int weight, input int cells,
                                              input int d0, input int d1, input int d2,
                                              input int d3, input bit last);
        kmga_pkg::t_net net;
        net.src_part  = kmga_pkg::PART_W'(home);
        net.net_wt    = kmga_pkg::WEIGHT_W'(weight);
        net.net_cells = kmga_pkg::t_deg'(cells);
        net.deg_part0 = kmga_pkg::t_deg'(d0);
        net.deg_part1 = kmga_pkg::t_deg'(d1);
        net.deg_part2 = kmga_pkg::t_deg'(d2);
        net.deg_part3 = kmga_pkg::t_deg'(d3);
        net.last_net  = last;
        return net;
    endfunction

    // random net, mostly shaped to hit one of the two gain rules
    function automatic kmga_pkg::t_net random_net(input int home, input bit last,
                                                  input bit heavy);
        kmga_pkg::t_deg cells;
        kmga_pkg::t_deg deg [kmga_pkg::CARRIED_PARTS];
        int             kind, tgt, twin;
        int             hp;
        kind  = heavy ? 4 : $urandom_range(0, 9);
        hp    = home;
        cells = ($urandom_range(0, 3) == 0) ? kmga_pkg::t_deg'($urandom_range(0, 1023))
                                            : kmga_pkg::t_deg'($urandom_range(1, 12));
        for (int p = 0; p < kmga_pkg::CARRIED_PARTS; p++) begin
            deg[p] = kmga_pkg::t_deg'($urandom_range(0, 15));
        end
        case (kind)
            0, 1, 2, 3: begin
                // cell alone at home, the rest gathered in another part
                if (cells == 0) begin
                    cells = kmga_pkg::t_deg'(1);
                end
                deg[hp] = kmga_pkg::t_deg'(1);
                tgt = $urandom_range(0, kmga_pkg::CARRIED_PARTS - 2);
                if (tgt >= hp) begin
                    tgt++;
                end
                deg[tgt] = cells - 1'b1;
                twin = $urandom_range(0, kmga_pkg::CARRIED_PARTS - 1);
                if ($urandom_range(0, 1) == 1 && twin != hp) begin
                    deg[twin] = cells - 1'b1;
                end
            end
            4, 5, 6: begin
                // whole net inside the home part
                if (!heavy && $urandom_range(0, 7) == 0) begin
                    cells = '0;
                end
                deg[hp] = cells;
            end
            7: begin
                // net with this cell only
                cells = kmga_pkg::t_deg'(1);
                for (int p = 0; p < kmga_pkg::CARRIED_PARTS; p++) begin
                    deg[p] = kmga_pkg::t_deg'($urandom_range(0, 2));
                end
                deg[hp] = kmga_pkg::t_deg'(1);
            end
            default: begin
                hp    = $urandom_range(0, 3);
                cells = kmga_pkg::t_deg'($urandom_range(0, 1023));
                for (int p = 0; p < kmga_pkg::CARRIED_PARTS; p++) begin
                    deg[p] = kmga_pkg::t_deg'($urandom_range(0, 1023));
                end
            end
        endcase
        return mk_net(hp, heavy ? $urandom_range(60000, 65535) : $urandom_range(0, 65535),
                      cells, deg[0], deg[1], deg[2], deg[3], last);
    endfunction

    // offer one net request and hold it until taken, then maybe idle
    task automatic send_net(input kmga_pkg::t_net net);
        int gap;
        net_ch.valid <= 1'b1;
        net_ch.data  <= net;
        @(posedge i_clk);
        while (!net_ch.ready) begin
            @(posedge i_clk);
        end
        nets_sent++;
        burst_left--;
        if (burst_left <= 0 && !hold_off_req) begin
            gap = $urandom_range(1, 12);
            net_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 16);
        end
    endtask

    // one cell: a run of nets, a lone empty item, or a long heavy run to saturate
    task automatic send_cell();
        int home, nets, pick;
        bit heavy;
        home  = $urandom_range(0, 3);
        pick  = $urandom_range(0, 39);
        heavy = (pick == 0);
        nets  = heavy ? $urandom_range(SAT_NETS, 30) : $urandom_range(1, 6);
        if (pick >= 1 && pick <= 3) begin
            send_net(mk_net(home, 0, $urandom_range(1, 12), 0, 0, 0, 0, 1'b1));
        end else begin
            for (int i = 0; i < nets; i++) begin
                send_net(random_net(home, i == nets - 1, heavy));
            end
        end
    endtask

    // stop offering and wait for every owed gain request
    task automatic wait_all_gains();
        net_ch.valid <= 1'b0;
        @(posedge i_clk);
        wait (pending_gains == 0);
        @(posedge i_clk);
    endtask

    // gain receiver: changing stall patterns plus one long hold-off on request
    initial begin : gain_receiver
        int         mode, span;
        logic [7:0] rhythm;
        rhythm = 8'b1011_0010;
        forever begin
            if (hold_off_req) begin
                for (int c = 0; c < HOLD_CYCLES; c++) begin
                    gain_ch.ready <= 1'b0;
                    @(posedge i_clk);
                end
                hold_off_req = 1'b0;
            end else begin
                mode = $urandom_range(0, 2);
                span = $urandom_range(10, 150);
                for (int c = 0; c < span && !hold_off_req; c++) begin
                    case (mode)
                        0: gain_ch.ready <= 1'b1;
                        1: gain_ch.ready <= ($urandom_range(0, 3) != 0);
                        default: begin
                            gain_ch.ready <= rhythm[0];
                            rhythm = {rhythm[0], rhythm[7:1]};
                        end
                    endcase
                    @(posedge i_clk);
                end
            end
        end
    end

    // net sender and verdict
    initial begin : net_sender
        bit pressure_done;
        pressure_done = 1'b0;
        net_ch.valid <= 1'b0;
        net_ch.data  <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        burst_left = $urandom_range(1, 16);

        // directed: empty cell, extremes, the lowest-part rule, zero and single-cell nets
        send_net(mk_net(0, 0, 1, 0, 0, 0, 0, 1'b1));
        send_net(mk_net(0, 65535, 1023, 1023, 0, 0, 0, 1'b0));
        send_net(mk_net(1, 1, 5, 4, 1, 4, 0, 1'b1));
        send_net(mk_net(2, 300, 1, 3, 0, 1, 0, 1'b0));
        send_net(mk_net(3, 77, 0, 5, 5, 5, 0, 1'b0));
        send_net(mk_net(3, 99, 0, 1023, 1023, 1023, 1, 1'b0));
        send_net(mk_net(0, 12345, 2, 1, 0, 0, 1, 1'b0));
        send_net(mk_net(1, 5, 3, 0, 1, 0, 0, 1'b1));
        send_net(mk_net(3, 65535, 1023, 1023, 1023, 1023, 1023, 1'b1));
        // saturation of one part
        for (int i = 0; i < SAT_NETS; i++) begin
            send_net(mk_net(1, 65535, 7, 0, 7, 0, 0, i == SAT_NETS - 1));
        end
        wait_all_gains();

        // random cells, with one long receiver hold-off half way
        while (nets_sent < NET_TARGET) begin
            if (!pressure_done && nets_sent >= NET_TARGET / 2) begin
                hold_off_req = 1'b1;
                while (hold_off_req) begin
                    send_cell();
                end
                wait_all_gains();
                pressure_done = 1'b1;
            end
            send_cell();
        end
        wait_all_gains();
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("PASS kway_move_gain_accumulator");
        end else begin
            $display("FAIL kway_move_gain_accumulator");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/kmga_pkg.sv
sv/kmga_net_if.sv
sv/kmga_gain_if.sv
sv/kmga_net_decode.sv
sv/kway_move_gain_accumulator.sv
bench/kmga_gain_checker.sv
bench/kway_move_gain_accumulator_tb.sv
